[hw/rtl/fspt_pkg.sv]
package fspt_pkg;

	localparam int NUM_USERS = 16;
	localparam int FRAC_BITS = 16;
	localparam int IDX_W     = (NUM_USERS > 1) ? $clog2(NUM_USERS) : 1;
	localparam int PEN_W     = 32 + FRAC_BITS;
	// 101 * max penalty
	localparam int DEN_W     = PEN_W + 7;
	// product of a 24-bit operand and a DEN_W operand
	localparam int X_W       = 24 + DEN_W;
	localparam int STEP_W    = $clog2(PEN_W + 1);

	localparam logic [PEN_W-1:0] PEN_MAX = {PEN_W{1'b1}};
	localparam logic [PEN_W-1:0] ONE_RAW = PEN_W'(1) << FRAC_BITS;

	localparam logic [1:0] ACT_CHARGE = 2'd0;
	localparam logic [1:0] ACT_QUERY  = 2'd1;
	localparam logic [1:0] ACT_SET    = 2'd2;
	localparam logic [1:0] ACT_CLEAR  = 2'd3;

	localparam logic [1:0] REG_DECAY   = 2'd0;
	localparam logic [1:0] REG_MEMORY  = 2'd1;
	localparam logic [1:0] REG_THREADS = 2'd2;

	typedef struct packed {
		logic [1:0]  action;
		logic [3:0]  user;
		logic [15:0] time_limit;
		logic [31:0] max_memory;
		logic [9:0]  threads;
		logic        decay_enable;
		logic [15:0] queued_mask;
		logic [15:0] priority_factor;
	} req_t;

	typedef struct packed {
		logic        status;
		logic [23:0] user_priority;
	} rsp_t;

	typedef enum logic {
		MD_MUL,
		MD_DIV
	} md_mode_e;

	typedef struct packed {
		logic             start;
		md_mode_e         mode;
		logic [STEP_W-1:0] steps;
		logic [23:0]      a;
		logic [DEN_W-1:0] b;
		logic [DEN_W-1:0] r_init;
		logic [X_W-1:0]   x_init;
	} md_req_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_MS,
		S_TS,
		S_SC,
		S_DECAY,
		S_MIN,
		S_SUB,
		S_MAX,
		S_NUM,
		S_MULQ,
		S_DIVQ,
		S_FINISH
	} state_e;

endpackage

[hw/rtl/fspt_muldiv.sv]
// shift-add multiply (msb of a first) or restoring divide, one bit per cycle
module fspt_muldiv (
	input  logic                            clk,
	input  logic                            arst_n,
	input  fspt_pkg::md_req_t               req,
	output logic                            busy,
	output logic                            done,
	output logic [fspt_pkg::X_W-1:0]        x
);
	import fspt_pkg::*;

	logic              busy_q;
	logic              done_q;
	md_mode_e          mode_q;
	logic [STEP_W-1:0] cnt_q;
	logic [23:0]       a_q;
	logic [DEN_W-1:0]  b_q;
	logic [DEN_W-1:0]  r_q;
	logic [X_W-1:0]    x_q;

	logic [DEN_W:0]    t;
	logic              ge;
	logic [DEN_W:0]    t_sub;
	logic [X_W-1:0]    x_mul;

	always_comb begin
		t     = {r_q, x_q[X_W-1]};
		ge    = t >= {1'b0, b_q};
		t_sub = t - {1'b0, b_q};
		x_mul = {x_q[X_W-2:0], 1'b0} + (a_q[23] ? X_W'(b_q) : X_W'(0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			mode_q <= req.mode;
			a_q    <= req.a;
			b_q    <= req.b;
			r_q    <= req.r_init;
			x_q    <= req.x_init;
		end else if (busy_q) begin
			if (mode_q == MD_MUL) begin
				x_q <= x_mul;
				a_q <= {a_q[22:0], 1'b0};
			end else begin
				r_q <= ge ? t_sub[DEN_W-1:0] : t[DEN_W-1:0];
				x_q <= {x_q[X_W-2:0], ge};
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign x    = x_q;

endmodule

[hw/rtl/fair_share_penalty_tracker_core.sv]
// channel | dir | handshake          | payload
// in      | in  | in_valid/in_stall  | in_data  (req_t)
// out     | out | out_valid/out_stall| out_data (rsp_t)
// cfg     | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One request at a time. Set, clear and a bad user go from dispatch straight to finish.
// Charge: about (32+F) + (10+F) + 24 divide/multiply steps in the shared unit, then
// walks of NUM_USERS slots for decay (if enabled), add/min and subtract.
// Query: NUM_USERS-slot max walk, then 24 multiply and 24 divide steps.
// Reset clears the active marks and penalties at once; factors are undefined until set.
// A finished result waits in the output register while the next request is taken.
module fair_share_penalty_tracker_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  fspt_pkg::req_t in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output fspt_pkg::rsp_t out_data,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [1:0]     cfg_index,
	input  logic [31:0]    cfg_data
);
	import fspt_pkg::*;

	state_e state_q, state_d;

	logic [16:0] decay_q;
	logic [31:0] mem_avail_q;
	logic [9:0]  thr_avail_q;

	logic                 act_q [NUM_USERS];
	logic [PEN_W-1:0]     pen_q [NUM_USERS];
	logic [15:0]          fac_q [NUM_USERS];

	req_t             req_q;
	logic [IDX_W-1:0] idx_q;
	logic [PEN_W-1:0] ms_q;
	logic [PEN_W-1:0] score_q;
	logic [PEN_W-1:0] ext_q;
	logic [PEN_W-1:0] pu_q;
	logic [DEN_W-1:0] den_q;
	logic             stat_q;
	logic [23:0]      prio_q;
	logic             out_valid_q;
	rsp_t             res_q;

	md_req_t          md_req;
	logic             md_busy;
	logic             md_done;
	logic [X_W-1:0]   md_x;

	fspt_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.busy   (md_busy),
		.done   (md_done),
		.x      (md_x)
	);

	logic [6:0]       user_ext;
	logic             in_range;
	logic [IDX_W-1:0] uidx;
	logic             uvalid;
	logic             last;
	logic [6:0]       idx_ext;
	logic             queued;
	logic [PEN_W-1:0] pen_cur;
	logic             act_cur;
	logic [16:0]      dcl;
	logic [PEN_W+16:0] dprod;
	logic [PEN_W:0]   addsum;
	logic [PEN_W-1:0] addv;
	logic [PEN_W-1:0] ts;
	logic [PEN_W-1:0] share;
	logic [DEN_W-1:0] den;
	logic [DEN_W-1:0] num;
	logic [31:0]      am;
	logic [9:0]       at;
	logic             finish_go;

	always_comb begin
		user_ext = {3'b0, req_q.user};
		in_range = user_ext < 7'(NUM_USERS);
		uidx     = user_ext[IDX_W-1:0];
		uvalid   = in_range && act_q[uidx];
		last     = idx_q == IDX_W'(NUM_USERS - 1);
		idx_ext  = 7'(idx_q);
		queued   = (idx_ext < 7'd16) && req_q.queued_mask[idx_ext[3:0]];
		pen_cur  = pen_q[idx_q];
		act_cur  = act_q[idx_q];
		dcl      = (decay_q > 17'd65536) ? 17'd65536 : decay_q;
		dprod    = pen_cur * dcl;
		addsum   = {1'b0, pen_cur} + {1'b0, score_q};
		addv     = addsum[PEN_W] ? PEN_MAX : addsum[PEN_W-1:0];
		ts       = PEN_W'(md_x[10+FRAC_BITS-1:0]);
		share    = (ms_q > ts) ? ms_q : ts;
		den      = DEN_W'(ext_q) * DEN_W'(101);
		num      = den - DEN_W'(pu_q) * DEN_W'(100);
		am       = (mem_avail_q == 32'd0) ? 32'd1 : mem_avail_q;
		at       = (thr_avail_q == 10'd0) ? 10'd1 : thr_avail_q;
		finish_go = !out_valid_q || !out_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		md_req        = '0;
		md_req.mode   = MD_MUL;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_DISPATCH;
			end
			S_DISPATCH: begin
				state_d = S_FINISH;
				if (uvalid && req_q.action == ACT_CHARGE) begin
					md_req.start  = 1'b1;
					md_req.mode   = MD_DIV;
					md_req.steps  = STEP_W'(PEN_W);
					md_req.b      = DEN_W'(am);
					md_req.x_init = {req_q.max_memory, {(X_W-32){1'b0}}};
					state_d       = S_MS;
				end else if (uvalid && req_q.action == ACT_QUERY) begin
					state_d = S_MAX;
				end
			end
			S_MS: begin
				if (md_done) begin
					md_req.start  = 1'b1;
					md_req.mode   = MD_DIV;
					md_req.steps  = STEP_W'(10 + FRAC_BITS);
					md_req.b      = DEN_W'(at);
					md_req.x_init = {req_q.threads, {(X_W-10){1'b0}}};
					state_d       = S_TS;
				end
			end
			S_TS: begin
				if (md_done) begin
					md_req.start = 1'b1;
					md_req.steps = STEP_W'(24);
					md_req.a     = {8'b0, req_q.time_limit};
					md_req.b     = DEN_W'(share);
					state_d      = S_SC;
				end
			end
			S_SC: begin
				if (md_done) state_d = req_q.decay_enable ? S_DECAY : S_MIN;
			end
			S_DECAY: begin
				if (last) state_d = S_MIN;
			end
			S_MIN: begin
				if (last) state_d = S_SUB;
			end
			S_SUB: begin
				if (last) state_d = S_FINISH;
			end
			S_MAX: begin
				if (last) state_d = S_NUM;
			end
			S_NUM: begin
				md_req.start = 1'b1;
				md_req.steps = STEP_W'(24);
				md_req.a     = {fac_q[uidx], 8'b0};
				md_req.b     = num;
				state_d      = S_MULQ;
			end
			S_MULQ: begin
				if (md_done) begin
					md_req.start  = 1'b1;
					md_req.mode   = MD_DIV;
					md_req.steps  = STEP_W'(24);
					md_req.b      = den_q;
					md_req.r_init = md_x[X_W-1:24];
					md_req.x_init = {md_x[23:0], {DEN_W{1'b0}}};
					state_d       = S_DIVQ;
				end
			end
			S_DIVQ: begin
				if (md_done) state_d = S_FINISH;
			end
			S_FINISH: begin
				if (finish_go) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign in_stall  = state_q != S_IDLE;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_q     <= 17'd65536;
			mem_avail_q <= 32'd1;
			thr_avail_q <= 10'd1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_DECAY:   decay_q     <= cfg_data[16:0];
				REG_MEMORY:  mem_avail_q <= cfg_data;
				REG_THREADS: thr_avail_q <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_USERS; i++) begin
				act_q[i] <= 1'b0;
				pen_q[i] <= '0;
			end
		end else begin
			case (state_q)
				S_DISPATCH: begin
					if (req_q.action == ACT_SET && in_range && !act_q[uidx]) begin
						act_q[uidx] <= 1'b1;
						pen_q[uidx] <= '0;
					end else if (req_q.action == ACT_CLEAR) begin
						for (int i = 0; i < NUM_USERS; i++) pen_q[i] <= '0;
					end
				end
				S_DECAY: begin
					if (act_cur && !queued) pen_q[idx_q] <= dprod[PEN_W+15:16];
				end
				S_MIN: begin
					if (idx_q == uidx) pen_q[idx_q] <= addv;
				end
				S_SUB: begin
					if (act_cur) pen_q[idx_q] <= pen_cur - ext_q;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) req_q <= in_data;
		if (state_q == S_DISPATCH && req_q.action == ACT_SET && in_range)
			fac_q[uidx] <= req_q.priority_factor;
	end

	// walk index, share/score, running min or max, status and priority
	always_ff @(posedge clk) begin
		case (state_q)
			S_DISPATCH: begin
				idx_q  <= '0;
				ext_q  <= ONE_RAW;
				prio_q <= '0;
				stat_q <= (req_q.action == ACT_SET) ? !in_range :
				          (req_q.action == ACT_CLEAR) ? 1'b0 : !uvalid;
			end
			S_MS: begin
				if (md_done) ms_q <= md_x[PEN_W-1:0];
			end
			S_SC: begin
				if (md_done) begin
					score_q <= (md_x[X_W-1:PEN_W] != '0) ? PEN_MAX : md_x[PEN_W-1:0];
					ext_q   <= PEN_MAX;
				end
			end
			S_DECAY: begin
				idx_q <= last ? '0 : idx_q + IDX_W'(1);
			end
			S_MIN: begin
				idx_q <= last ? '0 : idx_q + IDX_W'(1);
				if (idx_q == uidx) begin
					if (addv < ext_q) ext_q <= addv;
				end else if (act_cur && pen_cur < ext_q) begin
					ext_q <= pen_cur;
				end
			end
			S_SUB: begin
				idx_q <= last ? '0 : idx_q + IDX_W'(1);
			end
			S_MAX: begin
				idx_q <= last ? '0 : idx_q + IDX_W'(1);
				if (act_cur && pen_cur > ext_q) ext_q <= pen_cur;
				if (idx_q == uidx) pu_q <= pen_cur;
			end
			S_NUM: begin
				den_q <= den;
			end
			S_DIVQ: begin
				if (md_done) prio_q <= md_x[23:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_FINISH && finish_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FINISH && finish_go) begin
			res_q.status        <= stat_q;
			res_q.user_priority <= prio_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = res_q;

	a_md_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		md_req.start |-> !md_busy)
		else $error("shared unit started while busy");

	a_sub_ge_min: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SUB && act_cur) |-> pen_cur >= ext_q)
		else $error("active penalty below subtracted minimum");

	a_prio_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH && req_q.action == ACT_QUERY && !stat_q)
		|-> prio_q <= {fac_q[uidx], 8'b0})
		else $error("priority exceeds factor");

	a_out_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_FINISH))
		else $error("result shown outside finish");

endmodule
